/* sv/ilst_pkg.sv */
// Package for the indexed list store: transfer types, codes and cell control.
`timescale 1ns / 1ps
`default_nettype none
package ilst_pkg;

    typedef enum logic [2:0] {
        MODE_READ      = 3'd0,
        MODE_INS_FRONT = 3'd1,
        MODE_INS_BACK  = 3'd2,
        MODE_INS_AT    = 3'd3,
        MODE_DELETE    = 3'd4
    } ilst_mode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } ilst_status_t;

    localparam logic signed [31:0] READ_BAD_VALUE = -32'sd1;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [7:0]  position;
        logic signed [31:0] value;
    } ilst_in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         length;
    } ilst_out_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic               ins;
        logic               del;
        logic signed [31:0] value;
    } ilst_ctrl_t;

endpackage
`default_nettype wire

/* sv/ilst_cell.sv */
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module ilst_cell
    import ilst_pkg::*;
#(
    parameter int POS_W = 7,
    parameter int IDX   = 0
)
(
    input  wire logic               clk,
    input  wire ilst_ctrl_t         ctrl,
    input  wire logic [POS_W-1:0]   pos,
    input  wire logic signed [31:0] left_data,
    input  wire logic signed [31:0] right_data,
    output logic signed [31:0]      data,
    output logic signed [31:0]      rd_data
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (MY_IDX == pos)
                data_next = ctrl.value;
            else if (MY_IDX > pos)
                data_next = left_data;
        end
        else if (ctrl.del)
        begin
            if (MY_IDX >= pos)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // gated for the OR-combine in the top level
    assign rd_data = (MY_IDX == pos) ? data_reg : '0;

endmodule
`default_nettype wire

/* sv/indexed_list_store_top.sv */
// Top level of the indexed list store: decode, length counter and the cell chain.
// Latency: a command transferred at one edge has its result on the ports (done high)
// in the next cycle; one command per cycle, busy stays low.
// Each cell takes its neighbor's entry in the same cycle, so inserts and deletes
// anywhere in the list need no entry-by-entry shifting; reads OR-combine the cell outputs.
// Reset clears the length and the result strobe; entries are undefined until written.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module indexed_list_store_top
    import ilst_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire ilst_in_t cmd,
    output logic          done,
    output ilst_out_t     result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] CAP_VAL = CW'(CAPACITY);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               done_reg;
    ilst_out_t          result_reg;
    ilst_out_t          result_next;

    logic               accept;
    logic               neg;
    logic [WW-1:0]      pos_ext;
    logic [WW-1:0]      cnt_ext;
    logic               full;
    ilst_ctrl_t         ctrl;
    logic [CW-1:0]      cell_pos;
    logic signed [31:0] rd_any;

    logic signed [31:0] cell_data [CAPACITY];
    logic signed [31:0] cell_rd   [CAPACITY];

    // no multi-cycle work: a command is taken in every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign neg     = cmd.position[7];
    assign pos_ext = WW'(cmd.position[6:0]);
    assign cnt_ext = WW'(count_reg);
    assign full    = (count_reg == CAP_VAL);

    // Decode: shift command for the chain, status and the next length.
    always_comb
    begin
        ctrl.ins    = 1'b0;
        ctrl.del    = 1'b0;
        ctrl.value  = cmd.value;
        cell_pos    = CW'(cmd.position[6:0]);
        count_next  = count_reg;
        result_next.read_value = '0;
        result_next.status     = ST_DONE;
        unique case (cmd.mode)
            MODE_READ:
            begin
                if (neg || pos_ext >= cnt_ext)
                begin
                    result_next.read_value = READ_BAD_VALUE;
                    result_next.status     = ST_RANGE;
                end
                else
                begin
                    result_next.read_value = rd_any;
                end
            end
            MODE_INS_FRONT, MODE_INS_BACK:
            begin
                if (cmd.mode == MODE_INS_FRONT)
                    cell_pos = '0;
                else
                    cell_pos = count_reg;
                if (full)
                    result_next.status = ST_FULL;
                else
                begin
                    ctrl.ins   = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_INS_AT:
            begin
                if (neg || pos_ext > cnt_ext)
                    result_next.status = ST_RANGE;
                else if (full)
                    result_next.status = ST_FULL;
                else
                begin
                    ctrl.ins   = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_DELETE:
            begin
                if (neg || pos_ext >= cnt_ext)
                    result_next.status = ST_RANGE;
                else
                begin
                    ctrl.del   = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                result_next.status = ST_RANGE;
            end
        endcase
        result_next.length = 7'(count_next);
    end

    // Cell chain: cell i sees cell i-1 on its left and cell i+1 on its right.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left_d;
        logic signed [31:0] right_d;
        if (i == 0)
        begin : g_first
            assign left_d = cell_data[i];
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        ilst_cell #(
            .POS_W (CW),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .pos        (cell_pos),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // Only the addressed cell drives a nonzero read word.
    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_any = rd_any | cell_rd[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

/* tb/tb_indexed_list_store_top.sv */
// Testbench for the indexed list store: directed and random operations checked against a list model.
`timescale 1ns / 1ps
`default_nettype none
module tb_indexed_list_store_top;
    import ilst_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_OPS  = 300;
    // codes past the defined operations; the block must flag these
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    ilst_in_t  cmd;
    logic      done;
    ilst_out_t result;

    // model of the list contents and the results still owed by the block
    logic signed [31:0] held_entries[$];
    ilst_out_t          pending_results[$];

    int  mismatch_count;
    int  cycle_count;
    bit  gaps_on;
    int  reads_sent;
    int  inserts_sent;
    int  deletes_sent;
    int  unknown_sent;
    int  full_rejects;
    int  range_flags;
    int  peak_length;

    indexed_list_store_top #(
        .CAPACITY (STORE_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run guard: anything still stuck past this point is a hang.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Apply one operation to the list model and return what the block should answer.
    function automatic ilst_out_t apply_list_op(input ilst_in_t c);
        ilst_out_t   r;
        bit          neg;
        int unsigned pos;
        int          n;
        neg          = c.position[7];
        pos          = int'($unsigned(c.position));
        n            = held_entries.size();
        r.read_value = '0;
        r.status     = ST_DONE;
        case (c.mode)
            MODE_READ:
            begin
                if (neg || pos >= n)
                begin
                    r.read_value = READ_BAD_VALUE;
                    r.status     = ST_RANGE;
                end
                else
                    r.read_value = held_entries[pos];
            end
            MODE_INS_FRONT:
            begin
                if (n >= STORE_DEPTH)
                    r.status = ST_FULL;
                else
                    held_entries.push_front(c.value);
            end
            MODE_INS_BACK:
            begin
                if (n >= STORE_DEPTH)
                    r.status = ST_FULL;
                else
                    held_entries.push_back(c.value);
            end
            MODE_INS_AT:
            begin
                // position check wins over the full check
                if (neg || pos > n)
                    r.status = ST_RANGE;
                else if (n >= STORE_DEPTH)
                    r.status = ST_FULL;
                else
                    held_entries.insert(pos, c.value);
            end
            MODE_DELETE:
            begin
                if (neg || pos >= n)
                    r.status = ST_RANGE;
                else
                    held_entries.delete(pos);
            end
            default:
                r.status = ST_RANGE;
        endcase
        r.length = 7'(held_entries.size());
        return r;
    endfunction

    // Result checker: every strobe must match the oldest owed result.
    always @(posedge clk)
    begin
        ilst_out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result strobe with no transfer outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.read_value !== want.read_value)
                begin
                    $error("read_value mismatch: expected %0d, got %0d",
                           want.read_value, result.read_value);
                    mismatch_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, result.status);
                    mismatch_count++;
                end
                if (result.length !== want.length)
                begin
                    $error("length mismatch: expected %0d, got %0d",
                           want.length, result.length);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one command; the transfer happens at the first rising edge with busy low.
    // With gaps on, each cycle idles with a chance of 29 in a hundred.
    task automatic send_cmd(input logic [2:0] m, input logic signed [7:0] p,
                            input logic signed [31:0] v);
        ilst_in_t  item;
        ilst_out_t want;
        item.mode     = m;
        item.position = p;
        item.value    = v;
        if (gaps_on)
        begin
            while ($urandom_range(99) < 29)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= item;
        do
            @(posedge clk);
        while (busy);
        want = apply_list_op(item);
        pending_results.push_back(want);
        case (m)
            MODE_READ:                               reads_sent++;
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: inserts_sent++;
            MODE_DELETE:                             deletes_sent++;
            default:                                 unknown_sent++;
        endcase
        if (want.status == ST_FULL)
            full_rejects++;
        if (want.status == ST_RANGE)
            range_flags++;
        if (held_entries.size() > peak_length)
            peak_length = held_entries.size();
    endtask

    // Hold off new commands until every owed result has come back.
    task automatic wait_results_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a legal position up to hi; sometimes anything in the 8-bit range.
    function automatic logic signed [7:0] pick_position(input int hi);
        if (hi < 0 || $urandom_range(99) < 15)
            return 8'($urandom);
        return 8'($urandom_range(0, hi));
    endfunction

    // Empty list: every read and delete is out of range, as are bad insert points
    // and the unused operation codes.
    task automatic test_empty_list();
        send_cmd(MODE_READ, 8'sd0, 32'sd0);
        send_cmd(MODE_READ, -8'sd128, 32'sd0);
        send_cmd(MODE_READ, 8'sd127, 32'sd0);
        send_cmd(MODE_DELETE, 8'sd0, 32'sd0);
        send_cmd(MODE_DELETE, -8'sd1, 32'sd0);
        send_cmd(MODE_INS_AT, 8'sd1, 32'sd5);
        send_cmd(MODE_INS_AT, -8'sd1, 32'sd5);
        for (logic [3:0] m = 4'(MODE_UNUSED_LO); m <= 4'(MODE_UNUSED_HI); m++)
            send_cmd(m[2:0], 8'($urandom), $urandom);
    endtask

    // Extreme values through every insert kind, append at position == length,
    // reads of each slot, then deletes in the middle and at the front.
    task automatic test_value_extremes();
        send_cmd(MODE_INS_FRONT, 8'sd0, 32'sh7fffffff);
        send_cmd(MODE_INS_BACK, -8'sd128, 32'sh80000000);
        send_cmd(MODE_INS_AT, 8'sd1, -32'sd1);
        send_cmd(MODE_INS_AT, 8'sd3, 32'sd0);
        for (int i = 0; i < 4; i++)
            send_cmd(MODE_READ, 8'(i), $urandom);
        send_cmd(MODE_READ, 8'sd4, 32'sd0);
        send_cmd(MODE_DELETE, 8'sd1, $urandom);
        send_cmd(MODE_READ, 8'sd1, 32'sd0);
        send_cmd(MODE_DELETE, 8'sd0, 32'sd0);
        send_cmd(MODE_READ, 8'sd0, 32'sd0);
        wait_results_drained();
    endtask

    // Fill to capacity with mixed inserts, probe the full cases, then empty it again.
    task automatic test_full_store();
        logic [2:0] m;
        while (held_entries.size() < STORE_DEPTH)
        begin
            m = 3'($urandom_range(MODE_INS_FRONT, MODE_INS_AT));
            send_cmd(m, 8'($urandom_range(0, held_entries.size())), pick_value());
        end
        wait_results_drained();
        send_cmd(MODE_INS_FRONT, 8'sd0, $urandom);
        send_cmd(MODE_INS_BACK, 8'sd0, $urandom);
        send_cmd(MODE_INS_AT, 8'(STORE_DEPTH), $urandom);     // full
        send_cmd(MODE_INS_AT, 8'(STORE_DEPTH + 1), $urandom); // range beats full
        send_cmd(MODE_INS_AT, -8'sd1, $urandom);
        send_cmd(MODE_READ, 8'(STORE_DEPTH - 1), 32'sd0);
        send_cmd(MODE_READ, 8'(STORE_DEPTH), 32'sd0);
        send_cmd(MODE_DELETE, 8'(STORE_DEPTH - 1), 32'sd0);
        send_cmd(MODE_INS_BACK, 8'sd0, pick_value());
        send_cmd(MODE_DELETE, 8'(STORE_DEPTH), 32'sd0);
        while (held_entries.size() > 0)
        begin
            if ($urandom_range(3) == 0)
                send_cmd(MODE_READ, pick_position(held_entries.size() - 1), $urandom);
            send_cmd(MODE_DELETE, pick_position(held_entries.size() - 1), $urandom);
        end
        send_cmd(MODE_READ, 8'sd0, 32'sd0);
    endtask

    // Random mix; the grow bias flips now and then so the length wanders
    // over the whole range.
    task automatic test_random_ops();
        bit         grow;
        int         r;
        int         n;
        logic [2:0] m;
        logic signed [7:0] p;
        grow = 1'b1;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            gaps_on = !(i >= 150 && i < 300);
            if (i % 40 == 0)
                grow = 1'($urandom_range(1));
            if (i % 125 == 124)
                wait_results_drained();
            n = held_entries.size();
            r = $urandom_range(99);
            if (r < 5)
            begin
                m = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
                p = 8'($urandom);
            end
            else if (r < 30)
            begin
                m = MODE_READ;
                p = pick_position(n - 1);
            end
            else if (r < (grow ? 75 : 50) || n == 0)
            begin
                m = 3'($urandom_range(MODE_INS_FRONT, MODE_INS_AT));
                p = pick_position(n);
            end
            else
            begin
                m = MODE_DELETE;
                p = pick_position(n - 1);
            end
            send_cmd(m, p, pick_value());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        gaps_on        = 1'b1;
        reads_sent     = 0;
        inserts_sent   = 0;
        deletes_sent   = 0;
        unknown_sent   = 0;
        full_rejects   = 0;
        range_flags    = 0;
        peak_length    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_value_extremes();
        test_full_store();
        test_random_ops();

        wait_results_drained();
        repeat (4) @(posedge clk);

        $display("Covered %0d reads, %0d inserts, %0d deletes, %0d unknown operations",
                 reads_sent, inserts_sent, deletes_sent, unknown_sent);
        $display("Peak length %0d, %0d rejected as full, %0d flagged out of range",
                 peak_length, full_rejects, range_flags);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
